>>> hw/rtl/smpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smpq_pkg: shared definitions for the sorted min-priority queue
// Holds the queue capacity, derived widths, request kind codes, the
// controller state type and the command bundle to the datapath.
// ----------------------------------------------------------------------------
package smpq_pkg;

    localparam int CAPACITY = 16;
    localparam int OCC_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 5;

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_APPLY
    } t_state;

    typedef struct packed {
        logic load_req;
        logic apply;
    } t_dp_cmd;

endpackage

>>> hw/rtl/smpq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smpq_ctrl: request sequencer for the sorted min-priority queue
// Takes one request at a time, lets the datapath apply it once the output
// register is free, and keeps the output valid flag.
// ----------------------------------------------------------------------------
module smpq_ctrl
    import smpq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  logic    i_out_stall,
    output logic    o_out_valid,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_out_valid    = r_out_valid && i_out_stall;
        o_in_stall     = 1'b1;
        o_cmd.load_req = 1'b0;
        o_cmd.apply    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = ST_APPLY;
                end
            end
            ST_APPLY: begin
                if (out_free) begin
                    o_cmd.apply = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

>>> hw/rtl/smpq_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smpq_datapath: sorted storage cells and result register
// A row of compare-and-shift cells holds the entries in ascending order;
// a push inserts in one step and a pop shifts the row down by one.
// ----------------------------------------------------------------------------
module smpq_datapath
    import smpq_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    input  logic                     i_in_kind,
    input  logic signed [DATA_W-1:0] i_in_value,
    output logic signed [DATA_W-1:0] o_out_head_value,
    output logic                     o_out_is_empty,
    output logic [COUNT_W-1:0]       o_out_entry_count,
    output logic                     o_out_push_dropped
);

    logic                     r_req_kind;
    logic signed [DATA_W-1:0] r_req_value;
    logic signed [DATA_W-1:0] r_entry [CAPACITY];
    logic signed [DATA_W-1:0] n_entry [CAPACITY];
    logic [OCC_W-1:0]         r_occ;
    logic [OCC_W-1:0]         n_occ;
    logic                     stay    [CAPACITY];
    logic                     full;
    logic                     n_dropped;
    logic [OCC_W+COUNT_W-1:0] occ_ext;

    logic signed [DATA_W-1:0] r_head;
    logic                     r_empty;
    logic [COUNT_W-1:0]       r_count;
    logic                     r_dropped;

    assign full = (r_occ == OCC_W'(CAPACITY));

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        assign stay[g] = (OCC_W'(g) < r_occ) && (r_entry[g] < r_req_value);

        always_comb begin
            n_entry[g] = r_entry[g];
            if (r_req_kind == KIND_POP) begin
                if (g < CAPACITY - 1) begin
                    n_entry[g] = r_entry[(g + 1) % CAPACITY];
                end
            end else if (!full && !stay[g]) begin
                if (g == 0) begin
                    n_entry[g] = r_req_value;
                end else if (stay[(g + CAPACITY - 1) % CAPACITY]) begin
                    n_entry[g] = r_req_value;
                end else begin
                    n_entry[g] = r_entry[(g + CAPACITY - 1) % CAPACITY];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_cmd.apply) begin
                r_entry[g] <= n_entry[g];
            end
        end
    end

    always_comb begin
        n_occ     = r_occ;
        n_dropped = 1'b0;
        if (r_req_kind == KIND_POP) begin
            if (r_occ != '0) begin
                n_occ = r_occ - OCC_W'(1);
            end
        end else if (full) begin
            n_dropped = 1'b1;
        end else begin
            n_occ = r_occ + OCC_W'(1);
        end
    end

    assign occ_ext = {{COUNT_W{1'b0}}, n_occ};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else if (i_cmd.apply) begin
            r_occ <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req_kind  <= i_in_kind;
            r_req_value <= i_in_value;
        end
        if (i_cmd.apply) begin
            r_head    <= (n_occ == '0) ? '0 : n_entry[0];
            r_empty   <= (n_occ == '0);
            r_count   <= occ_ext[COUNT_W-1:0];
            r_dropped <= n_dropped;
        end
    end

    assign o_out_head_value   = r_head;
    assign o_out_is_empty     = r_empty;
    assign o_out_entry_count  = r_count;
    assign o_out_push_dropped = r_dropped;

endmodule

>>> hw/rtl/sorted_min_priority_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_min_priority_queue_core: min-priority queue of signed 32-bit values
// Keeps up to CAPACITY values in ascending order and reports the smallest.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one request: a kind (push or pop) and a value.
// Each request yields exactly one result on the output channel: the smallest
// stored value (zero when empty), an empty flag, the entry count modulo 32
// and a flag for a push that found the queue full and was discarded.
// A pop from an empty queue changes nothing and reports the empty queue.
// With the output register free, the result is valid once the request has
// passed the request register and been applied into the result register.
// The controller accepts a request while idle and applies it to the row of
// sorting cells in its apply state, and takes no new request before that.
// A finished result waits in the output register while the next request is
// accepted; that request is applied only once the output register is free,
// so a stalled receiver holds off the input after one further request.
// Reset empties the queue, returns the controller to idle and clears the
// output valid flag; stored values are not cleared, as only occupied cells
// are ever read.
// ----------------------------------------------------------------------------
module sorted_min_priority_queue_core
    import smpq_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic                     i_in_kind,
    input  logic signed [DATA_W-1:0] i_in_value,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [DATA_W-1:0] o_out_head_value,
    output logic                     o_out_is_empty,
    output logic [COUNT_W-1:0]       o_out_entry_count,
    output logic                     o_out_push_dropped
);

    t_dp_cmd cmd;

    smpq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    smpq_datapath u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .i_in_kind          (i_in_kind),
        .i_in_value         (i_in_value),
        .o_out_head_value   (o_out_head_value),
        .o_out_is_empty     (o_out_is_empty),
        .o_out_entry_count  (o_out_entry_count),
        .o_out_push_dropped (o_out_push_dropped)
    );

    a_apply_needs_free_slot: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        cmd.apply |-> (!o_out_valid || !i_out_stall)
    ) else $error("request applied while a result was still held");

    a_apply_gives_result: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        cmd.apply |=> o_out_valid
    ) else $error("applied request produced no result");

    a_accept_loads_request: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |-> cmd.load_req
    ) else $error("accepted request was not captured");

    a_drop_only_when_stored: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_push_dropped) |-> !o_out_is_empty
    ) else $error("dropped push reported with an empty queue");

endmodule

>>> bench/sorted_min_priority_queue_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_min_priority_queue_core_tb: self-checking bench for the queue core
// A short table of directed push and pop requests covers the empty queue, the
// value extremes, equal values and pushes into a full queue. Random bursts
// then fill and drain the queue many times. Both channels idle at random, and
// the receiver holds off once for a long stretch. Each result is compared
// field by field with a typed table row or the bench's sorted-array model.
// ----------------------------------------------------------------------------
module sorted_min_priority_queue_core_tb;
    import smpq_pkg::*;

    localparam int RANDOM_REQUESTS = 1400;
    localparam int MAX_GAP         = 13;
    localparam int LONG_HOLD       = 300;
    localparam int HOLD_AT_RESULT  = 400;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES    = 16;

    typedef struct {
        logic signed [DATA_W-1:0] head_value;
        logic                     is_empty;
        logic [COUNT_W-1:0]       entry_count;
        logic                     push_dropped;
    } t_queue_result;

    typedef struct {
        logic                     kind;
        logic signed [DATA_W-1:0] value;
        bit                       typed;
        t_queue_result            result;
    } t_request_row;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_stall;
    logic                     i_in_kind;
    logic signed [DATA_W-1:0] i_in_value;
    logic                     o_out_valid;
    logic                     i_out_stall;
    logic signed [DATA_W-1:0] o_out_head_value;
    logic                     o_out_is_empty;
    logic [COUNT_W-1:0]       o_out_entry_count;
    logic                     o_out_push_dropped;

    logic signed [DATA_W-1:0] model_values [CAPACITY];
    int                       model_count   = 0;
    t_queue_result            pending_results [$];
    t_request_row             directed_rows [$];
    int                       failures      = 0;
    int                       send_gap      = 0;
    int                       send_stretch  = 0;
    bit                       send_busy     = 1'b0;
    int                       recv_stretch  = 0;
    bit                       recv_busy     = 1'b0;
    int                       results_seen  = 0;
    int                       idle_cycles   = 0;

    sorted_min_priority_queue_core u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_in_kind          (i_in_kind),
        .i_in_value         (i_in_value),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_out_head_value   (o_out_head_value),
        .o_out_is_empty     (o_out_is_empty),
        .o_out_entry_count  (o_out_entry_count),
        .o_out_push_dropped (o_out_push_dropped)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_queue_result apply_to_model(input logic kind,
                                                     input logic signed [DATA_W-1:0] value);
        t_queue_result r;
        int            pos;
        r.push_dropped = 1'b0;
        if (kind == KIND_PUSH) begin
            if (model_count >= CAPACITY) begin
                r.push_dropped = 1'b1;
            end else begin
                pos = 0;
                while (pos < model_count && model_values[pos] < value) pos++;
                for (int i = model_count; i > pos; i--) model_values[i] = model_values[i-1];
                model_values[pos] = value;
                model_count++;
            end
        end else if (model_count > 0) begin
            for (int i = 1; i < model_count; i++) model_values[i-1] = model_values[i];
            model_count--;
        end
        r.head_value  = (model_count > 0) ? model_values[0] : '0;
        r.is_empty    = (model_count == 0);
        r.entry_count = model_count[COUNT_W-1:0];
        return r;
    endfunction

    function automatic int draw_gap(ref int stretch_left, ref bit busy);
        if (stretch_left == 0) begin
            stretch_left = $urandom_range(20, 80);
            busy         = ($urandom_range(0, 2) == 0);
        end
        stretch_left--;
        return busy ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    function automatic void add_checked_row(input logic kind,
                                            input logic signed [DATA_W-1:0] value);
        t_request_row row;
        row.kind  = kind;
        row.value = value;
        row.typed = 1'b0;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_typed_row(input logic kind,
                                          input logic signed [DATA_W-1:0] value,
                                          input logic signed [DATA_W-1:0] head,
                                          input logic is_empty,
                                          input logic [COUNT_W-1:0] count,
                                          input logic dropped);
        t_request_row row;
        row.kind                = kind;
        row.value               = value;
        row.typed               = 1'b1;
        row.result.head_value   = head;
        row.result.is_empty     = is_empty;
        row.result.entry_count  = count;
        row.result.push_dropped = dropped;
        directed_rows.push_back(row);
    endfunction

    task automatic send_request(input t_request_row row);
        t_queue_result predicted;
        repeat (send_gap) @(posedge i_clk);
        i_in_valid <= 1'b1;
        i_in_kind  <= row.kind;
        i_in_value <= row.value;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predicted = apply_to_model(row.kind, row.value);
        pending_results.push_back(row.typed ? row.result : predicted);
        send_gap = draw_gap(send_stretch, send_busy);
        if (send_gap != 0) i_in_valid <= 1'b0;
    endtask

    initial begin
        t_request_row row;
        int           burst_left;
        int           push_pct;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_kind  <= KIND_PUSH;
        i_in_value <= '0;
        burst_left = 0;
        push_pct   = 50;

        add_typed_row(KIND_POP,  32'sd0,          32'sd0,          1'b1, 5'd0,  1'b0);
        add_typed_row(KIND_PUSH, 32'sh7FFFFFFF,   32'sh7FFFFFFF,   1'b0, 5'd1,  1'b0);
        add_typed_row(KIND_PUSH, 32'sh80000000,   32'sh80000000,   1'b0, 5'd2,  1'b0);
        add_checked_row(KIND_PUSH, 32'sd0);
        add_checked_row(KIND_PUSH, -32'sd1);
        add_checked_row(KIND_PUSH, 32'sd1);
        add_checked_row(KIND_PUSH, 32'sh80000000);
        add_checked_row(KIND_PUSH, 32'sd100);
        add_checked_row(KIND_PUSH, -32'sd100);
        add_checked_row(KIND_PUSH, 32'sd42);
        add_checked_row(KIND_PUSH, 32'sd7);
        add_checked_row(KIND_PUSH, 32'sd7);
        add_checked_row(KIND_PUSH, -32'sd7);
        add_checked_row(KIND_PUSH, 32'sd1000);
        add_checked_row(KIND_PUSH, 32'sh40000000);
        add_checked_row(KIND_PUSH, 32'shC0000000);
        add_checked_row(KIND_PUSH, 32'sd3);
        add_typed_row(KIND_PUSH, 32'sd5,          32'sh80000000,   1'b0, 5'd16, 1'b1);
        add_typed_row(KIND_PUSH, 32'sh80000000,   32'sh80000000,   1'b0, 5'd16, 1'b1);
        add_checked_row(KIND_POP, 32'sd0);
        add_checked_row(KIND_POP, 32'shFFFFFFFF);
        add_checked_row(KIND_POP, 32'sd0);
        add_checked_row(KIND_PUSH, 32'sh7FFFFFFF);
        add_checked_row(KIND_POP, 32'sd0);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[n]) send_request(directed_rows[n]);

        // Bursts lean towards pushes or pops so that the queue swings between
        // empty and full, with narrow value ranges to produce equal values.
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(10, 60);
                case ($urandom_range(0, 2))
                    0: push_pct = 85;
                    1: push_pct = 15;
                    default: push_pct = 55;
                endcase
            end
            burst_left--;
            row.typed = 1'b0;
            row.kind  = ($urandom_range(0, 99) < push_pct) ? KIND_PUSH : KIND_POP;
            case ($urandom_range(0, 3))
                0: row.value = $urandom_range(0, 15) - 8;
                1: begin
                    case ($urandom_range(0, 3))
                        0: row.value = 32'sh7FFFFFFF;
                        1: row.value = 32'sh80000000;
                        2: row.value = 32'sd0;
                        default: row.value = -32'sd1;
                    endcase
                end
                default: row.value = $urandom();
            endcase
            send_request(row);
        end
        if (send_gap == 0) i_in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (failures == 0 && pending_results.size() == 0) begin
            $display("sorted_min_priority_queue_core_tb: PASS");
        end else begin
            $display("sorted_min_priority_queue_core_tb: FAIL");
        end
        $finish;
    end

    // Result side: random hold-offs between results, and one long hold-off
    // during which the sender keeps offering requests until the core fills.
    initial begin
        int            hold;
        t_queue_result want;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    $error("result with no request outstanding: head_value %0d",
                           o_out_head_value);
                    failures++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_out_head_value !== want.head_value) begin
                        $error("head_value: expected %0d, actual %0d",
                               want.head_value, o_out_head_value);
                        failures++;
                    end
                    if (o_out_is_empty !== want.is_empty) begin
                        $error("is_empty: expected %0d, actual %0d",
                               want.is_empty, o_out_is_empty);
                        failures++;
                    end
                    if (o_out_entry_count !== want.entry_count) begin
                        $error("entry_count: expected %0d, actual %0d",
                               want.entry_count, o_out_entry_count);
                        failures++;
                    end
                    if (o_out_push_dropped !== want.push_dropped) begin
                        $error("push_dropped: expected %0d, actual %0d",
                               want.push_dropped, o_out_push_dropped);
                        failures++;
                    end
                end
                results_seen++;
                hold = (results_seen == HOLD_AT_RESULT) ? LONG_HOLD
                                                        : draw_gap(recv_stretch, recv_busy);
                if (hold != 0) begin
                    i_out_stall <= 1'b1;
                    repeat (hold) @(posedge i_clk);
                    i_out_stall <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("sorted_min_priority_queue_core_tb: FAIL");
            $finish;
        end
    end

endmodule

>>> sorted_min_priority_queue_core.f
hw/rtl/smpq_pkg.sv
hw/rtl/smpq_ctrl.sv
hw/rtl/smpq_datapath.sv
hw/rtl/sorted_min_priority_queue_core.sv
bench/sorted_min_priority_queue_core_tb.sv
